// ===== hw/rtl/urm_pkg.sv =====
`default_nettype none

package urm_pkg;

  // Item kinds on the input channel. The fourth code has no meaning and is
  // served by a default arm wherever the kind is decoded.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RX    = 2'd2
  } op_t;

  // Register offsets from the device base.
  localparam logic [2:0] OFF_RBR = 3'd0;
  localparam logic [2:0] OFF_IER = 3'd1;
  localparam logic [2:0] OFF_IIR = 3'd2;
  localparam logic [2:0] OFF_LCR = 3'd3;
  localparam logic [2:0] OFF_MCR = 3'd4;
  localparam logic [2:0] OFF_LSR = 3'd5;
  localparam logic [2:0] OFF_MSR = 3'd6;
  localparam logic [2:0] OFF_SCR = 3'd7;

  // Fixed register values and bit masks.
  localparam logic [7:0] MSR_VALUE     = 8'h90;
  localparam logic [7:0] IER_MASK      = 8'h0f;
  localparam logic [7:0] IIR_FIFO_BITS = 8'hC0;
  localparam logic [7:0] IIR_RX_DATA   = 8'h04;
  localparam logic [7:0] IIR_TX_EMPTY  = 8'h02;
  localparam logic [7:0] IIR_NONE      = 8'h01;
  localparam logic [7:0] LSR_DR_BIT    = 8'h01;
  localparam logic [7:0] LSR_THRE_BIT  = 8'h20;
  localparam logic [7:0] LSR_TEMT_BIT  = 8'h40;

  // Bit positions inside registers.
  localparam int DLAB_POS     = 7;
  localparam int IE_RX_POS    = 0;
  localparam int IE_TX_POS    = 1;
  localparam int FCR_CLR_POS  = 1;

  // Depth of the output queue.
  localparam logic [1:0] Q_FULL = 2'd2;

  // One result item as delivered on the output channel.
  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_overflow;
    logic       irq;
  } result_t;

  // Result of the decode stage; read_data comes from the FIFO memory
  // when use_mem is set.
  typedef struct packed {
    result_t res;
    logic    use_mem;
  } stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/urm_rx_mem.sv =====
`default_nettype none

module urm_rx_mem #(
  parameter int RX_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(RX_DEPTH)-1:0] wr_addr,
  input  wire logic [7:0]                  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(RX_DEPTH)-1:0] rd_addr,
  output logic      [7:0]                  rd_data
);

  logic [7:0] mem [RX_DEPTH];

  // Synchronous write port and registered read port; read data holds
  // until the next read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/urm_ctrl.sv =====
`default_nettype none

module urm_ctrl #(
  parameter int RX_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        accept,
  input  wire logic [1:0]                  opcode,
  input  wire logic [2:0]                  reg_offset,
  input  wire logic [7:0]                  data,
  input  wire logic                        p_move,
  output logic                             mem_wr_en,
  output logic      [$clog2(RX_DEPTH)-1:0] mem_wr_addr,
  output logic      [7:0]                  mem_wr_data,
  output logic                             mem_rd_en,
  output logic      [$clog2(RX_DEPTH)-1:0] mem_rd_addr,
  output logic                             p_valid,
  output urm_pkg::stage_t                  p_stage
);

  import urm_pkg::*;

  localparam int PTR_W  = $clog2(RX_DEPTH);
  localparam int FILL_W = $clog2(RX_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RX_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RX_DEPTH);

  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [3:0]        ier, ier_next;
  logic [7:0]        lcr, lcr_next;
  logic [7:0]        mcr, mcr_next;
  logic [7:0]        scr, scr_next;
  logic [7:0]        dll, dll_next;
  logic [7:0]        dlm, dlm_next;
  logic              pend, pend_next;
  stage_t            st;
  logic              dlab;
  logic              rx_act;
  logic              tx_act;

  assign dlab   = lcr[DLAB_POS];
  assign rx_act = ier[IE_RX_POS] && (fill != '0);
  assign tx_act = ier[IE_TX_POS] && pend;

  assign mem_wr_addr = tail;
  assign mem_wr_data = data;
  assign mem_rd_addr = head;

  // Decode of one transaction: register updates, FIFO pointer moves and
  // the partial result.
  always_comb begin
    head_next = head;
    tail_next = tail;
    fill_next = fill;
    ier_next  = ier;
    lcr_next  = lcr;
    mcr_next  = mcr;
    scr_next  = scr;
    dll_next  = dll;
    dlm_next  = dlm;
    pend_next = pend;
    mem_wr_en = 1'b0;
    mem_rd_en = 1'b0;
    st        = '0;
    if (accept) begin
      case (op_t'(opcode))
        OP_READ: begin
          unique case (reg_offset)
            OFF_RBR: begin
              if (dlab) begin
                st.res.read_data = dll;
              end else if (fill != '0) begin
                mem_rd_en  = 1'b1;
                st.use_mem = 1'b1;
                head_next  = (head == PTR_LAST) ? '0 : head + 1'b1;
                fill_next  = fill - 1'b1;
              end
            end
            OFF_IER: st.res.read_data = dlab ? dlm : {4'b0, ier};
            OFF_IIR: begin
              if (rx_act) begin
                st.res.read_data = IIR_FIFO_BITS | IIR_RX_DATA;
              end else if (tx_act) begin
                st.res.read_data = IIR_FIFO_BITS | IIR_TX_EMPTY;
                pend_next = 1'b0;
              end else begin
                st.res.read_data = IIR_FIFO_BITS | IIR_NONE;
              end
            end
            OFF_LCR: st.res.read_data = lcr;
            OFF_MCR: st.res.read_data = mcr;
            OFF_LSR: begin
              st.res.read_data = LSR_THRE_BIT | LSR_TEMT_BIT |
                                 ((fill != '0) ? LSR_DR_BIT : 8'h00);
            end
            OFF_MSR: st.res.read_data = MSR_VALUE;
            OFF_SCR: st.res.read_data = scr;
            default: st.res.read_data = 8'h00;
          endcase
        end
        OP_WRITE: begin
          unique case (reg_offset)
            OFF_RBR: begin
              if (dlab) begin
                dll_next = data;
              end else begin
                st.res.tx_valid = 1'b1;
                st.res.tx_byte  = data;
                if (ier[IE_TX_POS]) begin
                  pend_next = 1'b1;
                end
              end
            end
            OFF_IER: begin
              if (dlab) begin
                dlm_next = data;
              end else begin
                ier_next = 4'(data & IER_MASK);
                if (data[IE_TX_POS] && !ier[IE_TX_POS]) begin
                  pend_next = 1'b1;
                end
              end
            end
            OFF_IIR: begin
              if (data[FCR_CLR_POS]) begin
                head_next = '0;
                tail_next = '0;
                fill_next = '0;
              end
            end
            OFF_LCR: lcr_next = data;
            OFF_MCR: mcr_next = data;
            OFF_SCR: scr_next = data;
            default: ;
          endcase
        end
        OP_RX: begin
          if (fill == FILL_FULL) begin
            st.res.rx_overflow = 1'b1;
          end else begin
            mem_wr_en = 1'b1;
            tail_next = (tail == PTR_LAST) ? '0 : tail + 1'b1;
            fill_next = fill + 1'b1;
          end
        end
        default: ;
      endcase
    end
    // Interrupt level as it stands after this transaction.
    st.res.irq = (ier_next[IE_RX_POS] && (fill_next != '0)) ||
                 (ier_next[IE_TX_POS] && pend_next);
  end

  // Register file and FIFO pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
      ier  <= '0;
      lcr  <= '0;
      mcr  <= '0;
      scr  <= '0;
      dll  <= '0;
      dlm  <= '0;
      pend <= 1'b0;
    end else begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
      ier  <= ier_next;
      lcr  <= lcr_next;
      mcr  <= mcr_next;
      scr  <= scr_next;
      dll  <= dll_next;
      dlm  <= dlm_next;
      pend <= pend_next;
    end
  end

  // Decode stage register, aligned with the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= accept || (p_valid && !p_move);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_stage <= st;
    end
  end

  // The fill count stays within the FIFO depth.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("FIFO fill count exceeds depth");

  // An empty FIFO has its read and write positions together.
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> (head == tail))
    else $error("empty FIFO with pointers apart");

  // A memory read is always picked up by the decode stage.
  a_rd_stage: assert property (@(posedge clk) disable iff (rst)
    mem_rd_en |=> (p_valid && p_stage.use_mem))
    else $error("memory read without matching stage entry");

endmodule

`default_nettype wire

// ===== hw/rtl/urm_out_q.sv =====
`default_nettype none

module urm_out_q (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            p_valid,
  input  wire urm_pkg::stage_t p_stage,
  input  wire logic [7:0]      rd_data,
  output logic                 p_move,
  output logic      [1:0]      count,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic      [7:0]      read_data,
  output logic                 tx_valid,
  output logic      [7:0]      tx_byte,
  output logic                 rx_overflow,
  output logic                 irq
);

  import urm_pkg::*;

  result_t ent [2];
  logic    wr_ptr;
  logic    rd_ptr;
  logic    pop;
  result_t res_in;
  result_t res_out;

  assign pop    = out_valid && !out_stall;
  assign p_move = p_valid && ((count != Q_FULL) || pop);

  // Fill in the popped FIFO byte for a data register read.
  always_comb begin
    res_in = p_stage.res;
    if (p_stage.use_mem) begin
      res_in.read_data = rd_data;
    end
  end

  // Two-entry queue of finished results.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (p_move) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, p_move} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      ent[wr_ptr] <= res_in;
    end
  end

  assign out_valid   = (count != '0);
  assign res_out     = ent[rd_ptr];
  assign read_data   = res_out.read_data;
  assign tx_valid    = res_out.tx_valid;
  assign tx_byte     = res_out.tx_byte;
  assign rx_overflow = res_out.rx_overflow;
  assign irq         = res_out.irq;

  // The queue never holds more than two results.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= Q_FULL)
    else $error("output queue overfilled");

  // A full queue only takes a new result when one leaves.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (p_move && (count == Q_FULL)) |-> pop)
    else $error("push into a full output queue");

endmodule

`default_nettype wire

// ===== hw/rtl/uart_register_model_top.sv =====
`default_nettype none

// Simplified 16550 UART register file.
// Input channel (in_valid / in_stall) carries one transaction per item:
// a bus read, a bus write, or a received byte arriving (opcode, reg_offset,
// data). Output channel (out_valid / out_stall) returns exactly one result
// per transaction, in order: read_data, tx_valid, tx_byte, rx_overflow and
// the irq level after that transaction.
// Received bytes are kept in an RX_DEPTH-entry FIFO memory with a registered
// read port; registers and FIFO pointers update in the cycle the transaction
// is accepted, so back-to-back transactions see each other.
// The result of an accepted transaction is registered in the decode stage,
// then in the output queue, from which it is presented.
// Throughput is one transaction per cycle while the receiver keeps up.
// Reset empties the FIFO, zeroes every register and drops any results in
// flight. When the receiver stalls, up to three transactions are held (one
// in the decode stage, two in the output queue) before in_stall rises;
// in_stall is driven from registers only.
module uart_register_model_top #(
  parameter int RX_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [2:0] reg_offset,
  input  wire logic [7:0] data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] read_data,
  output logic            tx_valid,
  output logic      [7:0] tx_byte,
  output logic            rx_overflow,
  output logic            irq
);

  import urm_pkg::*;

  localparam int PTR_W = $clog2(RX_DEPTH);

  logic             accept;
  logic             mem_wr_en;
  logic [PTR_W-1:0] mem_wr_addr;
  logic [7:0]       mem_wr_data;
  logic             mem_rd_en;
  logic [PTR_W-1:0] mem_rd_addr;
  logic [7:0]       mem_rd_data;
  logic             p_valid;
  stage_t           p_stage;
  logic             p_move;
  logic [1:0]       q_count;

  // Hold off new transactions once the decode stage and queue are full.
  assign in_stall = p_valid && (q_count == Q_FULL);
  assign accept   = in_valid && !in_stall;

  urm_ctrl #(
    .RX_DEPTH (RX_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (opcode),
    .reg_offset  (reg_offset),
    .data        (data),
    .p_move      (p_move),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .p_valid     (p_valid),
    .p_stage     (p_stage)
  );

  urm_rx_mem #(
    .RX_DEPTH (RX_DEPTH)
  ) u_rx_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  urm_out_q u_out_q (
    .clk         (clk),
    .rst         (rst),
    .p_valid     (p_valid),
    .p_stage     (p_stage),
    .rd_data     (mem_rd_data),
    .p_move      (p_move),
    .count       (q_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .tx_valid    (tx_valid),
    .tx_byte     (tx_byte),
    .rx_overflow (rx_overflow),
    .irq         (irq)
  );

endmodule

`default_nettype wire
